[sv/crb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crb_pkg: shared types and constants of the CSR row builder
// Holds field widths, request and result codes and controller commands.
// ----------------------------------------------------------------------------
package crb_pkg;

    localparam int unsigned NodeCountDefault = 65536;
    localparam int unsigned MaxDegreeDefault = 32;
    localparam int unsigned NodeW            = 16;
    localparam int unsigned WeightW          = 32;
    localparam int unsigned PtrW             = 22;
    localparam int unsigned DegW             = 6;
    localparam logic [PtrW-1:0] TotalCap     = 22'd2097152;

    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_FINISH = 1'b1;
    localparam logic KIND_COL   = 1'b0;
    localparam logic KIND_PTR   = 1'b1;

    typedef struct packed {
        logic load;       // capture the input word
        logic scan_step;  // compare one stored entry against dst
        logic upd_wt;     // raise the weight of the matching entry
        logic append;     // store dst as a new entry
        logic set_ovf;    // mark the row as overflowed
        logic sel_init;   // start a selection pass for the next column
        logic sel_step;   // compare one entry during selection
        logic emit_col;   // drive a column word
        logic emit_ptr;   // drive the row pointer word
        logic close_row;  // empty the row and move to the new source
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic scan_hit;
        logic sel_done;
        logic row_empty;
        logic row_full;   // the row holds MAX_DEGREE entries
        logic flush_req;  // the captured word needs a flush
        logic add_req;    // the captured word adds an edge
        logic cols_left;  // columns still to emit
    } t_sts;

endpackage

[sv/crb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crb_in_if / crb_out_if: valid/ready channels of the CSR row builder
// Input channel carries edge requests, output channel carries CSR words.
// ----------------------------------------------------------------------------
interface crb_in_if import crb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [NodeW-1:0]   src;
    logic [NodeW-1:0]   dst;
    logic signed [WeightW-1:0] weight;
    modport source (output valid, req_type, src, dst, weight, input ready);
    modport sink   (input valid, req_type, src, dst, weight, output ready);
endinterface

interface crb_out_if import crb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [NodeW-1:0]   column;
    logic signed [WeightW-1:0] entry_weight;
    logic [PtrW-1:0]    row_pointer;
    logic [NodeW-1:0]   run_length;
    logic [NodeW-1:0]   best_node;
    logic [DegW-1:0]    best_degree;
    logic               dropped;
    logic               last;
    modport source (output valid, kind, column, entry_weight, row_pointer, run_length,
                    best_node, best_degree, dropped, last, input ready);
    modport sink   (input valid, kind, column, entry_weight, row_pointer, run_length,
                    best_node, best_degree, dropped, last, output ready);
endinterface

[sv/csr_row_builder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_row_builder: top level of the CSR row builder
// Builds CSR words from source-grouped weighted edges.
// ----------------------------------------------------------------------------
// An add edge is captured, decoded, searched one entry per cycle against the row
// (up to MAX_DEGREE entries) and stored. A flush runs a one-entry-per-cycle
// selection pass per column, then emits the row pointer; output stalls hold it.
// One word at a time in flight; a new word is taken only from idle.
// Reset (synchronous, active low) empties the row, sets the source to 1.
module csr_row_builder import crb_pkg::*; #(
    parameter int unsigned NODE_COUNT = NodeCountDefault,
    parameter int unsigned MAX_DEGREE = MaxDegreeDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    crb_in_if.sink     i_in,
    crb_out_if.source  o_out
);
    t_cmd cmd;
    t_sts sts;

    // sequence accept, flush and add; the datapath reports row status
    crb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    crb_datapath #(.NODE_COUNT(NODE_COUNT), .MAX_DEGREE(MAX_DEGREE)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_req_type     (i_in.req_type),
        .i_src          (i_in.src),
        .i_dst          (i_in.dst),
        .i_weight       (i_in.weight),
        .o_kind         (o_out.kind),
        .o_column       (o_out.column),
        .o_entry_weight (o_out.entry_weight),
        .o_row_pointer  (o_out.row_pointer),
        .o_run_length   (o_out.run_length),
        .o_best_node    (o_out.best_node),
        .o_best_degree  (o_out.best_degree),
        .o_dropped      (o_out.dropped),
        .o_last         (o_out.last)
    );
endmodule

[sv/crb_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crb_datapath: row store, search, selection and CSR word formation
// Scans one entry per cycle; the flush picks the next larger column by a
// one-entry-per-cycle minimum pass over the row.
// ----------------------------------------------------------------------------
module crb_datapath import crb_pkg::*; #(
    parameter int unsigned NODE_COUNT = NodeCountDefault,
    parameter int unsigned MAX_DEGREE = MaxDegreeDefault
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    input  logic                      i_req_type,
    input  logic [NodeW-1:0]          i_src,
    input  logic [NodeW-1:0]          i_dst,
    input  logic signed [WeightW-1:0] i_weight,
    output logic                      o_kind,
    output logic [NodeW-1:0]          o_column,
    output logic signed [WeightW-1:0] o_entry_weight,
    output logic [PtrW-1:0]           o_row_pointer,
    output logic [NodeW-1:0]          o_run_length,
    output logic [NodeW-1:0]          o_best_node,
    output logic [DegW-1:0]           o_best_degree,
    output logic                      o_dropped,
    output logic                      o_last
);
    localparam int unsigned IdxW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam logic [DegW-1:0] MaxDeg = DegW'(MAX_DEGREE);
    localparam logic [NodeW:0]  NodeLim = (NodeW+1)'(NODE_COUNT);

    logic [NodeW-1:0]          r_node [MAX_DEGREE];
    logic signed [WeightW-1:0] r_wt   [MAX_DEGREE];

    // 17-bit source so a finish may reach NODE_COUNT itself
    logic [NodeW:0]   r_cur, r_new;
    logic             r_req;
    logic [NodeW-1:0] r_dst;
    logic signed [WeightW-1:0] r_win;
    logic [DegW-1:0]  r_fill, r_scan, r_emitted;
    logic [PtrW-1:0]  r_total;
    logic [DegW-1:0]  r_topdeg;
    logic [NodeW-1:0] r_topnode;
    logic             r_ovf, r_hit;
    logic [IdxW-1:0]  r_hit_idx;
    // selection: previous emitted column and current best candidate
    logic [NodeW:0]   r_prev;  // bit NodeW set means nothing emitted yet
    logic [NodeW-1:0] r_cand;
    logic             r_cand_ok;
    logic signed [WeightW-1:0] r_cand_wt;

    logic [IdxW-1:0]  scan_idx;
    logic [NodeW-1:0] scan_node;
    logic             above_prev;
    logic [NodeW:0]   src_clip;
    logic [DegW-1:0]  deg_new;
    logic             deg_wins;

    assign scan_idx  = r_scan[IdxW-1:0];
    assign scan_node = r_node[scan_idx];
    assign above_prev = r_prev[NodeW] || ({1'b0, scan_node} > r_prev);
    assign src_clip  = ({1'b0, i_src} > NodeLim) ? NodeLim : {1'b0, i_src};
    assign deg_new   = r_fill;
    assign deg_wins  = deg_new > r_topdeg;

    always_comb begin
        o_sts.scan_done = (r_scan >= r_fill) || r_hit;
        o_sts.scan_hit  = r_hit;
        o_sts.sel_done  = (r_scan >= r_fill);
        o_sts.row_empty = (r_fill == '0);
        o_sts.row_full  = (r_fill >= MaxDeg);
        o_sts.cols_left = (r_emitted < r_fill);
        o_sts.flush_req = (r_new > r_cur) &&
                          (r_req || (r_new < NodeLim && {1'b0, r_dst} < NodeLim));
        o_sts.add_req   = !r_req && r_new < NodeLim && {1'b0, r_dst} < NodeLim;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur     <= (NodeW+1)'(1);
            r_fill    <= '0;
            r_total   <= '0;
            r_topdeg  <= '0;
            r_topnode <= '0;
            r_ovf     <= 1'b0;
            r_scan    <= '0;
            r_hit     <= 1'b0;
            r_emitted <= '0;
            r_prev    <= {1'b1, {NodeW{1'b0}}};
            r_cand_ok <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_req  <= i_req_type;
                r_new  <= i_req_type ? src_clip : {1'b0, i_src};
                r_dst  <= i_dst;
                r_win  <= i_weight;
                r_scan <= '0;
                r_hit  <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                if (scan_node == r_dst) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= scan_idx;
                end else begin
                    r_scan <= r_scan + 1'b1;
                end
            end
            if (i_cmd.upd_wt) begin
                if (r_wt[r_hit_idx] < r_win) r_wt[r_hit_idx] <= r_win;
            end
            if (i_cmd.append) begin
                r_node[r_fill[IdxW-1:0]] <= r_dst;
                r_wt[r_fill[IdxW-1:0]]   <= r_win;
                r_fill <= r_fill + 1'b1;
                if (r_total < TotalCap) r_total <= r_total + 1'b1;
            end
            if (i_cmd.set_ovf) r_ovf <= 1'b1;
            if (i_cmd.sel_init) begin
                r_scan    <= '0;
                r_cand_ok <= 1'b0;
            end
            if (i_cmd.sel_step) begin
                if (above_prev && (!r_cand_ok || scan_node < r_cand)) begin
                    r_cand    <= scan_node;
                    r_cand_wt <= r_wt[scan_idx];
                    r_cand_ok <= 1'b1;
                end
                r_scan <= r_scan + 1'b1;
            end
            if (i_cmd.emit_col) begin
                r_prev    <= {1'b0, r_cand};
                r_emitted <= r_emitted + 1'b1;
            end
            if (i_cmd.close_row && deg_wins) begin
                r_topdeg  <= deg_new;
                r_topnode <= r_cur[NodeW-1:0];
            end
            if (i_cmd.close_row) begin
                r_fill    <= '0;
                r_ovf     <= 1'b0;
                r_cur     <= r_new;
                r_emitted <= '0;
                r_prev    <= {1'b1, {NodeW{1'b0}}};
                r_scan    <= '0;
                r_hit     <= 1'b0;
            end
        end
    end

    // column fields hold steady while a column word waits for ready
    always_comb begin
        o_kind         = i_cmd.emit_ptr ? KIND_PTR : KIND_COL;
        o_column       = i_cmd.emit_ptr ? '0 : r_cand;
        o_entry_weight = i_cmd.emit_ptr ? '0 : r_cand_wt;
        o_row_pointer  = i_cmd.emit_ptr ? r_total : '0;
        o_run_length   = i_cmd.emit_ptr ? NodeW'(r_new - r_cur) : '0;
        o_best_node    = '0;
        o_best_degree  = '0;
        if (i_cmd.emit_ptr) begin
            o_best_node   = deg_wins ? r_cur[NodeW-1:0] : r_topnode;
            o_best_degree = deg_wins ? deg_new : r_topdeg;
        end
        o_dropped = i_cmd.emit_ptr && r_ovf;
        o_last    = i_cmd.emit_ptr;
    end
endmodule

[sv/crb_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crb_ctrl: sequencer of the CSR row builder
// Walks accept, flush (select/emit per column, then row pointer) and add.
// ----------------------------------------------------------------------------
module crb_ctrl import crb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DEC   = 8'b0000_0010,
        S_SINIT = 8'b0000_0100,
        S_SEL   = 8'b0000_1000,
        S_COL   = 8'b0001_0000,
        S_PTR   = 8'b0010_0000,
        S_SCAN  = 8'b0100_0000,
        S_ADD   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.flush_req)    n_state = S_SINIT;
                else if (i_sts.add_req) n_state = S_SCAN;
                else                    n_state = S_IDLE;
            end
            S_SINIT: begin
                o_cmd.sel_init = 1'b1;
                n_state = i_sts.cols_left ? S_SEL : S_PTR;
            end
            S_SEL: begin
                if (i_sts.sel_done) n_state = S_COL;
                else                o_cmd.sel_step = 1'b1;
            end
            S_COL: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.emit_col = 1'b1;
                    n_state = S_SINIT;
                end
            end
            S_PTR: begin
                o_out_valid = 1'b1;
                o_cmd.emit_ptr = 1'b1;
                if (i_out_ready) begin
                    o_cmd.close_row = 1'b1;
                    n_state = i_sts.add_req ? S_SCAN : S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_ADD;
                else                 o_cmd.scan_step = 1'b1;
            end
            S_ADD: begin
                if (i_sts.scan_hit)      o_cmd.upd_wt  = 1'b1;
                else if (i_sts.row_full) o_cmd.set_ovf = 1'b1;
                else                     o_cmd.append  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
